// File: design/regex_dot_star_matcher_unit_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef REGEX_DOT_STAR_MATCHER_UNIT_ASSERT_SVH
`define REGEX_DOT_STAR_MATCHER_UNIT_ASSERT_SVH

// Checks a property on every rising edge of i_clk while i_rst_n is high.
`define RDSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks a property on every rising edge of i_clk, reset included.
`define RDSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: design/rdsm_pkg.sv
package rdsm_pkg;

    localparam int unsigned LEN_W      = 5;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;
    localparam logic [BYTE_W-1:0] STAR_CHAR = 8'h2A;

    localparam logic [OP_W-1:0] OP_NEXT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LAST  = 2'd1;
    localparam logic [OP_W-1:0] OP_EMPTY = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    typedef struct packed {
        logic update;
        logic fresh;
    } t_cell_ctl;

endpackage

// File: design/rdsm_in_if.sv
interface rdsm_in_if;
    logic                          valid;
    logic                          ready;
    logic [rdsm_pkg::OP_W-1:0]     op;
    logic [rdsm_pkg::BYTE_W-1:0]   ch;

    modport source (output valid, output op, output ch, input ready);
    modport sink (input valid, input op, input ch, output ready);
endinterface

// File: design/rdsm_out_if.sv
interface rdsm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic string_done;

    modport source (output valid, output matched, output string_done, input ready);
    modport sink (input valid, input matched, input string_done, output ready);
endinterface

// File: design/rdsm_cell.sv
module rdsm_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rdsm_pkg::t_cell_ctl         i_ctl,
    input  logic                        i_en,
    input  logic                        i_has_prev,
    input  logic [rdsm_pkg::BYTE_W-1:0] i_pat,
    input  logic [rdsm_pkg::BYTE_W-1:0] i_pat_prev,
    input  logic [rdsm_pkg::BYTE_W-1:0] i_ch,
    input  logic                        i_old_prev,
    input  logic                        i_new_prev2,
    input  logic                        i_empty_prev2,
    output logic                        o_old,
    output logic                        o_new,
    output logic                        o_empty
);

    logic r_bit;
    logic n_bit;
    logic is_star;
    logic pat_hit;
    logic prev_hit;

    assign is_star  = (i_pat == rdsm_pkg::STAR_CHAR);
    assign pat_hit  = (i_pat == i_ch) || (i_pat == rdsm_pkg::DOT_CHAR);
    assign prev_hit = (i_pat_prev == i_ch) || (i_pat_prev == rdsm_pkg::DOT_CHAR);

    always_comb begin
        o_empty = i_en && is_star && i_has_prev && i_empty_prev2;
        o_old   = i_ctl.fresh ? o_empty : r_bit;
        if (is_star) begin
            o_new = i_en && i_has_prev && (i_new_prev2 || (prev_hit && o_old));
        end else begin
            o_new = i_en && pat_hit && i_old_prev;
        end
        n_bit = i_ctl.update ? o_new : r_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

endmodule

// File: design/regex_dot_star_matcher_unit.sv
// Channel  Dir  Fields              Handshake
// i_in     in   op, ch              valid/ready, beat taken when both high
// o_out    out  matched, string_done valid/ready, beat taken when both high
//
// One input beat is taken per cycle while the input is not held off; each gives one result beat in the next cycle.
// The row update ripples through the chain of pattern cells within the cycle in which the beat is taken.
// After reset the pattern is empty and the row holds the empty-string value.
// While a result beat waits in the output register, the input is held off.
module regex_dot_star_matcher_unit #(
    parameter int unsigned PATTERN_CHARS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rdsm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rdsm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rdsm_in_if.sink                         i_in,
    rdsm_out_if.source                      o_out
);

    localparam int unsigned IDX_W = $clog2(PATTERN_CHARS + 1);
    localparam logic [rdsm_pkg::LEN_W-1:0] MAX_LEN = rdsm_pkg::LEN_W'(PATTERN_CHARS);

    logic [rdsm_pkg::CFG_DATA_W-1:0] r_pat_low;
    logic [rdsm_pkg::CFG_DATA_W-1:0] r_pat_high;
    logic [rdsm_pkg::LEN_W-1:0]      r_len;
    logic                            r_fresh;
    logic                            n_fresh;
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic                            r_matched;
    logic                            r_done;

    logic [2*rdsm_pkg::CFG_DATA_W-1:0] pat_all;
    logic [rdsm_pkg::LEN_W-1:0]        len_sat;
    logic [PATTERN_CHARS:0]            old_bits;
    logic [PATTERN_CHARS:0]            new_bits;
    logic [PATTERN_CHARS:0]            empty_bits;
    logic                              in_acc;
    logic                              cfg_hit;
    logic                              is_next;
    logic                              res_matched;
    rdsm_pkg::t_cell_ctl               cell_ctl;

    assign pat_all = {r_pat_high, r_pat_low};
    assign len_sat = (r_len > MAX_LEN) ? MAX_LEN : r_len;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign is_next    = (i_in.op == rdsm_pkg::OP_NEXT);
    assign cfg_hit    = i_cfg_we && ((i_cfg_addr == rdsm_pkg::CFG_PATTERN_LOW) ||
                                     (i_cfg_addr == rdsm_pkg::CFG_PATTERN_HIGH) ||
                                     (i_cfg_addr == rdsm_pkg::CFG_PATTERN_LENGTH));

    assign cell_ctl.update = in_acc && is_next;
    assign cell_ctl.fresh  = r_fresh;

    assign old_bits[0]   = r_fresh;
    assign new_bits[0]   = 1'b0;
    assign empty_bits[0] = 1'b1;

    for (genvar j = 1; j <= PATTERN_CHARS; j++) begin : g_cell
        if (j == 1) begin : g_first
            rdsm_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (cell_ctl),
                .i_en          (rdsm_pkg::LEN_W'(j) <= len_sat),
                .i_has_prev    (1'b0),
                .i_pat         (pat_all[rdsm_pkg::BYTE_W*(j-1) +: rdsm_pkg::BYTE_W]),
                .i_pat_prev    ({rdsm_pkg::BYTE_W{1'b0}}),
                .i_ch          (i_in.ch),
                .i_old_prev    (old_bits[j-1]),
                .i_new_prev2   (1'b0),
                .i_empty_prev2 (1'b0),
                .o_old         (old_bits[j]),
                .o_new         (new_bits[j]),
                .o_empty       (empty_bits[j])
            );
        end else begin : g_rest
            rdsm_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (cell_ctl),
                .i_en          (rdsm_pkg::LEN_W'(j) <= len_sat),
                .i_has_prev    (1'b1),
                .i_pat         (pat_all[rdsm_pkg::BYTE_W*(j-1) +: rdsm_pkg::BYTE_W]),
                .i_pat_prev    (pat_all[rdsm_pkg::BYTE_W*(j-2) +: rdsm_pkg::BYTE_W]),
                .i_ch          (i_in.ch),
                .i_old_prev    (old_bits[j-1]),
                .i_new_prev2   (new_bits[j-2]),
                .i_empty_prev2 (empty_bits[j-2]),
                .o_old         (old_bits[j]),
                .o_new         (new_bits[j]),
                .o_empty       (empty_bits[j])
            );
        end
    end

    always_comb begin
        if (is_next || (i_in.op == rdsm_pkg::OP_LAST)) begin
            res_matched = new_bits[len_sat[IDX_W-1:0]];
        end else begin
            res_matched = empty_bits[len_sat[IDX_W-1:0]];
        end

        n_fresh = r_fresh;
        if (cfg_hit) begin
            n_fresh = 1'b1;
        end else if (in_acc) begin
            n_fresh = !is_next;
        end

        n_out_valid = r_out_valid;
        if (in_acc) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low   <= '0;
            r_pat_high  <= '0;
            r_len       <= '0;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    rdsm_pkg::CFG_PATTERN_LOW: begin
                        r_pat_low <= i_cfg_data;
                    end
                    rdsm_pkg::CFG_PATTERN_HIGH: begin
                        r_pat_high <= i_cfg_data;
                    end
                    rdsm_pkg::CFG_PATTERN_LENGTH: begin
                        r_len <= i_cfg_data[rdsm_pkg::LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_matched <= res_matched;
            r_done    <= !is_next;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.matched     = r_matched;
    assign o_out.string_done = r_done;

endmodule

// File: design/rdsm_checker.sv
`include "regex_dot_star_matcher_unit_assert.svh"

module rdsm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic [rdsm_pkg::OP_W-1:0]     i_in_op,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_done
);

    `RDSM_ASSERT(a_out_holds, i_out_valid && !i_out_ready |=> i_out_valid, "result beat dropped while stalled")
    `RDSM_ASSERT(a_result_follows, i_in_valid && i_in_ready |=> i_out_valid, "accepted beat gave no result")
    `RDSM_ASSERT(a_done_flag, i_in_valid && i_in_ready && (i_in_op != rdsm_pkg::OP_NEXT) |=> i_out_done, "string end not reported")
    `RDSM_ASSERT_ALWAYS(a_ready_stall, !i_in_ready |-> i_out_valid && !i_out_ready, "input stalled without a waiting result")

endmodule

bind regex_dot_star_matcher_unit rdsm_checker u_rdsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_done  (o_out.string_done)
);

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PAT_CHARS     = 16;
    localparam int unsigned IDLE_LIMIT    = 1000;
    localparam int unsigned SETTLE_CYCLES = 2;
    localparam int unsigned TAIL_ITEMS    = 150;
    localparam int unsigned RANDOM_BEATS  = 1230;

    localparam logic [rdsm_pkg::OP_W-1:0]       OP_SPARE  = 2'd3;
    localparam logic [rdsm_pkg::CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [rdsm_pkg::BYTE_W-1:0]     CHAR_A    = 8'h61;
    localparam logic [rdsm_pkg::BYTE_W-1:0]     CHAR_B    = 8'h62;

    typedef struct {
        logic                            is_cfg;
        logic [rdsm_pkg::CFG_ADDR_W-1:0] addr;
        logic [rdsm_pkg::CFG_DATA_W-1:0] data;
        logic [rdsm_pkg::OP_W-1:0]       op;
        logic [rdsm_pkg::BYTE_W-1:0]     ch;
    } t_feed;

    typedef struct packed {
        logic matched;
        logic string_done;
    } t_verdict;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [rdsm_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [rdsm_pkg::CFG_DATA_W-1:0] cfg_data;

    rdsm_in_if  in_if ();
    rdsm_out_if out_if ();

    regex_dot_star_matcher_unit #(
        .PATTERN_CHARS(PAT_CHARS)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_addr(cfg_addr),
        .i_cfg_data(cfg_data),
        .i_in      (in_if),
        .o_out     (out_if)
    );

    t_feed       feed [$];
    t_verdict    verdicts [$];
    int unsigned pending_results;
    int unsigned idle_cycles;
    int unsigned mismatches;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned settle;
    logic        feed_done;
    logic        quiet_tail;

    logic [rdsm_pkg::CFG_DATA_W-1:0] pat_lo;
    logic [rdsm_pkg::CFG_DATA_W-1:0] pat_hi;
    int unsigned                     pat_used;
    logic [16:0]                     match_row;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [rdsm_pkg::BYTE_W-1:0] pat_char(int k);
        logic [127:0] both;
        both = {pat_hi, pat_lo};
        return both[8*(k & 15) +: 8];
    endfunction

    function automatic logic [16:0] string_start_row();
        logic [16:0] r;
        r = 17'd1;
        for (int j = 1; j <= pat_used; j++) begin
            if (j >= 2 && pat_char(j - 1) == rdsm_pkg::STAR_CHAR && r[j-2]) begin
                r[j] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [16:0] row_after_char(logic [16:0] prev,
                                                   logic [rdsm_pkg::BYTE_W-1:0] c);
        logic [16:0]                 r;
        logic [rdsm_pkg::BYTE_W-1:0] p;
        logic [rdsm_pkg::BYTE_W-1:0] pp;
        r = '0;
        for (int j = 1; j <= pat_used; j++) begin
            p = pat_char(j - 1);
            if (p == rdsm_pkg::STAR_CHAR) begin
                if (j >= 2) begin
                    pp = pat_char(j - 2);
                    r[j] = r[j-2] | ((pp == c || pp == rdsm_pkg::DOT_CHAR) && prev[j]);
                end
            end else if (p == c || p == rdsm_pkg::DOT_CHAR) begin
                r[j] = prev[j-1];
            end
        end
        return r;
    endfunction

    function automatic logic [rdsm_pkg::BYTE_W-1:0] any_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return CHAR_A;
            3, 4, 5: return CHAR_B;
            6:       return rdsm_pkg::DOT_CHAR;
            7:       return rdsm_pkg::STAR_CHAR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_beat(logic [rdsm_pkg::OP_W-1:0] op, logic [rdsm_pkg::BYTE_W-1:0] ch);
        t_feed f;
        f.is_cfg = 1'b0;
        f.addr   = rdsm_pkg::CFG_PATTERN_LOW;
        f.data   = '0;
        f.op     = op;
        f.ch     = ch;
        feed.push_back(f);
    endtask

    task automatic add_cfg(logic [rdsm_pkg::CFG_ADDR_W-1:0] addr,
                           logic [rdsm_pkg::CFG_DATA_W-1:0] data);
        t_feed f;
        f.is_cfg = 1'b1;
        f.addr   = addr;
        f.data   = data;
        f.op     = rdsm_pkg::OP_NEXT;
        f.ch     = '0;
        feed.push_back(f);
    endtask

    always @(posedge i_clk) begin : drive_items
        t_feed head;
        logic  hold;
        logic  load;
        logic  write;
        hold  = in_if.valid && !in_if.ready;
        load  = 1'b0;
        write = 1'b0;
        if (!i_rst_n) begin
            gap_left = 0;
            settle   = 0;
            in_if.valid <= 1'b0;
            cfg_we      <= 1'b0;
            feed_done   <= 1'b0;
            quiet_tail  <= 1'b0;
        end else begin
            if (!hold) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (feed.size() != 0) begin
                    head = feed[0];
                    if (!head.is_cfg) begin
                        load = 1'b1;
                        feed.delete(0);
                        if (!quiet_tail && $urandom_range(0, 99) < 8) begin
                            gap_left = $urandom_range(1, 18);
                        end
                    end else if (pending_results == 0 && !in_if.valid && !cfg_we) begin
                        if (settle >= SETTLE_CYCLES) begin
                            write  = 1'b1;
                            settle = 0;
                            feed.delete(0);
                        end else begin
                            settle++;
                        end
                    end else begin
                        settle = 0;
                    end
                end
            end
            in_if.valid <= hold || load;
            cfg_we      <= write;
            if (load) begin
                in_if.op <= head.op;
                in_if.ch <= head.ch;
            end
            if (write) begin
                cfg_addr <= head.addr;
                cfg_data <= head.data;
            end
            feed_done  <= (feed.size() == 0);
            quiet_tail <= (feed.size() <= TAIL_ITEMS);
        end
    end

    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            stall_left = 0;
            out_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 99) < 6) begin
            stall_left = $urandom_range(0, 17);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_verdict want;
        logic     in_beat;
        logic     out_beat;
        in_beat  = in_if.valid && in_if.ready;
        out_beat = out_if.valid && out_if.ready;
        if (!i_rst_n) begin
            pat_lo    = '0;
            pat_hi    = '0;
            pat_used  = 0;
            match_row = string_start_row();
            verdicts.delete();
            pending_results <= 0;
            idle_cycles     <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    rdsm_pkg::CFG_PATTERN_LOW:    pat_lo = cfg_data;
                    rdsm_pkg::CFG_PATTERN_HIGH:   pat_hi = cfg_data;
                    rdsm_pkg::CFG_PATTERN_LENGTH: begin
                        pat_used = (cfg_data[4:0] > PAT_CHARS) ? PAT_CHARS : cfg_data[4:0];
                    end
                    default: ;
                endcase
                if (cfg_addr != CFG_SPARE) begin
                    match_row = string_start_row();
                end
            end
            if (out_beat) begin
                if (verdicts.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result beat: matched=%0b string_done=%0b",
                                 out_if.matched, out_if.string_done);
                    end
                    mismatches++;
                end else begin
                    want = verdicts.pop_front();
                    if (out_if.matched !== want.matched
                            || out_if.string_done !== want.string_done) begin
                        if (mismatches < 10) begin
                            $display("result mismatch: expected matched=%0b string_done=%0b, %s",
                                     want.matched, want.string_done,
                                     $sformatf("got matched=%0b string_done=%0b",
                                               out_if.matched, out_if.string_done));
                        end
                        mismatches++;
                    end
                end
            end
            if (in_beat) begin
                case (in_if.op)
                    rdsm_pkg::OP_NEXT, rdsm_pkg::OP_LAST: begin
                        match_row = row_after_char(match_row, in_if.ch);
                        want.matched     = match_row[pat_used];
                        want.string_done = (in_if.op == rdsm_pkg::OP_LAST);
                        if (in_if.op == rdsm_pkg::OP_LAST) begin
                            match_row = string_start_row();
                        end
                    end
                    default: begin
                        match_row = string_start_row();
                        want.matched     = match_row[pat_used];
                        want.string_done = 1'b1;
                    end
                endcase
                verdicts.push_back(want);
            end
            pending_results <= verdicts.size();
            idle_cycles     <= (in_beat || out_beat || cfg_we) ? 0 : idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [rdsm_pkg::BYTE_W-1:0]     pat [16];
        logic [rdsm_pkg::BYTE_W-1:0]     text [$];
        logic [127:0]                    pat_bits;
        logic [rdsm_pkg::CFG_DATA_W-1:0] len_word;
        logic [4:0]                      len_field;
        int unsigned                     eff_len;
        int unsigned                     beats;
        int unsigned                     k;
        int unsigned                     pick;

        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_addr        = rdsm_pkg::CFG_PATTERN_LOW;
        cfg_data        = '0;
        in_if.valid     = 1'b0;
        in_if.op        = rdsm_pkg::OP_NEXT;
        in_if.ch        = '0;
        out_if.ready    = 1'b0;
        feed_done       = 1'b0;
        quiet_tail      = 1'b0;
        pending_results = 0;
        idle_cycles     = 0;
        mismatches      = 0;

        // The empty pattern after reset matches only the empty string.
        add_beat(rdsm_pkg::OP_EMPTY, 8'h00);
        add_beat(rdsm_pkg::OP_NEXT, 8'h00);
        add_beat(rdsm_pkg::OP_LAST, 8'hFF);
        add_beat(OP_SPARE, 8'hA5);

        add_cfg(rdsm_pkg::CFG_PATTERN_LOW, 64'h0000_0000_0062_2A61);
        add_cfg(rdsm_pkg::CFG_PATTERN_LENGTH, 64'd3);
        add_beat(rdsm_pkg::OP_NEXT, CHAR_A);
        add_beat(rdsm_pkg::OP_NEXT, CHAR_A);
        add_beat(rdsm_pkg::OP_LAST, CHAR_B);
        add_beat(rdsm_pkg::OP_LAST, CHAR_B);
        add_beat(rdsm_pkg::OP_EMPTY, 8'h5A);

        // A star in the first pattern position has nothing to repeat.
        add_cfg(rdsm_pkg::CFG_PATTERN_LOW, 64'h0000_0000_0000_612A);
        add_cfg(rdsm_pkg::CFG_PATTERN_LENGTH, 64'd2);
        add_beat(rdsm_pkg::OP_LAST, CHAR_A);
        add_beat(OP_SPARE, 8'h00);

        // A second star repeats a literal star character.
        add_cfg(rdsm_pkg::CFG_PATTERN_LOW, 64'h0000_0000_002A_2A61);
        add_cfg(rdsm_pkg::CFG_PATTERN_LENGTH, 64'd3);
        add_beat(rdsm_pkg::OP_NEXT, CHAR_A);
        add_beat(rdsm_pkg::OP_NEXT, rdsm_pkg::STAR_CHAR);
        add_beat(rdsm_pkg::OP_LAST, rdsm_pkg::STAR_CHAR);
        add_beat(rdsm_pkg::OP_LAST, CHAR_A);

        // An oversized length saturates; the spare register index changes nothing.
        add_cfg(rdsm_pkg::CFG_PATTERN_LOW, 64'h2A2E_2A2E_2A2E_2A2E);
        add_cfg(rdsm_pkg::CFG_PATTERN_HIGH, 64'h2A2E_2A2E_2A2E_2A2E);
        add_cfg(rdsm_pkg::CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        add_beat(rdsm_pkg::OP_NEXT, 8'h00);
        add_cfg(CFG_SPARE, {$urandom, $urandom});
        add_beat(rdsm_pkg::OP_LAST, 8'hFF);

        // A register write in the middle of a string abandons it.
        add_cfg(rdsm_pkg::CFG_PATTERN_LOW, 64'h0000_0000_0000_6261);
        add_cfg(rdsm_pkg::CFG_PATTERN_LENGTH, 64'd2);
        add_beat(rdsm_pkg::OP_NEXT, CHAR_A);
        add_cfg(rdsm_pkg::CFG_PATTERN_LENGTH, 64'd2);
        add_beat(rdsm_pkg::OP_LAST, CHAR_B);

        beats = 19;
        while (beats < RANDOM_BEATS) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                len_field = 5'd0;
            end else if (pick < 4) begin
                len_field = 5'd16;
            end else if (pick == 4) begin
                len_field = 5'($urandom_range(17, 31));
            end else begin
                len_field = 5'($urandom_range(1, 10));
            end
            eff_len = (len_field > PAT_CHARS) ? PAT_CHARS : len_field;
            for (int i = 0; i < 16; i++) begin
                pick = $urandom_range(0, 99);
                if (i >= eff_len || pick >= 90) begin
                    pat[i] = 8'($urandom_range(0, 255));
                end else if (pick < 25) begin
                    pat[i] = CHAR_A;
                end else if (pick < 45) begin
                    pat[i] = CHAR_B;
                end else if (pick < 62) begin
                    pat[i] = rdsm_pkg::DOT_CHAR;
                end else begin
                    pat[i] = rdsm_pkg::STAR_CHAR;
                end
                pat_bits[8*i +: 8] = pat[i];
            end
            len_word = {$urandom, 27'($urandom), len_field};
            add_cfg(rdsm_pkg::CFG_PATTERN_LOW, pat_bits[63:0]);
            add_cfg(rdsm_pkg::CFG_PATTERN_HIGH, pat_bits[127:64]);
            add_cfg(rdsm_pkg::CFG_PATTERN_LENGTH, len_word);

            repeat ($urandom_range(4, 10)) begin
                text.delete();
                pick = $urandom_range(0, 9);
                if (pick < 8) begin
                    k = 0;
                    while (k < eff_len) begin
                        if (k + 1 < eff_len && pat[k+1] == rdsm_pkg::STAR_CHAR
                                && pat[k] != rdsm_pkg::STAR_CHAR) begin
                            repeat ($urandom_range(0, 3)) begin
                                text.push_back(pat[k] == rdsm_pkg::DOT_CHAR ? any_char()
                                                                            : pat[k]);
                            end
                            k += 2;
                        end else begin
                            if (pat[k] != rdsm_pkg::STAR_CHAR) begin
                                text.push_back(pat[k] == rdsm_pkg::DOT_CHAR ? any_char()
                                                                            : pat[k]);
                            end
                            k++;
                        end
                    end
                    if (pick == 7 && text.size() != 0) begin
                        text[$urandom_range(0, text.size() - 1)] = any_char();
                    end
                end else begin
                    repeat ($urandom_range(0, 6)) begin
                        text.push_back(any_char());
                    end
                end

                if (text.size() == 0) begin
                    add_beat($urandom_range(0, 1) ? rdsm_pkg::OP_EMPTY : OP_SPARE,
                             8'($urandom_range(0, 255)));
                    beats++;
                end else begin
                    foreach (text[i]) begin
                        if (i != 0 && $urandom_range(0, 49) == 0) begin
                            if ($urandom_range(0, 1)) begin
                                add_cfg(CFG_SPARE, {$urandom, $urandom});
                            end else begin
                                add_cfg(rdsm_pkg::CFG_PATTERN_LENGTH, len_word);
                            end
                        end
                        add_beat(i == text.size() - 1 ? rdsm_pkg::OP_LAST : rdsm_pkg::OP_NEXT,
                                 text[i]);
                    end
                    beats += text.size();
                end
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(feed_done && !in_if.valid && pending_results == 0)
                && idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
        end else begin
            repeat (8) @(posedge i_clk);
            if (mismatches == 0 && pending_results == 0) begin
                $display("testbench OK");
            end else begin
                $display("testbench NOT OK");
            end
        end
        $finish;
    end

endmodule
